// File: hw/rtl/ahs_pkg.sv
// shared types and codes for the autonomy handoff supervisor
`timescale 1ns / 1ps
package ahs_pkg;
	localparam logic [2:0] OP_TICK = 3'd0;
	localparam logic [2:0] OP_MEAS = 3'd1;
	localparam logic [2:0] OP_VEL  = 3'd2;
	localparam logic [2:0] OP_STOP = 3'd3;
	localparam logic [2:0] OP_MISS = 3'd4;
	localparam logic [2:0] OP_UPD  = 3'd5;

	localparam logic [2:0] MODE_NOHB  = 3'd0;
	localparam logic [2:0] MODE_WAITHB = 3'd1;
	localparam logic [2:0] MODE_HAND  = 3'd2;
	localparam logic [2:0] MODE_READY = 3'd3;
	localparam logic [2:0] MODE_RUN   = 3'd4;

	localparam logic [1:0] DBW_OFF   = 2'd0;
	localparam logic [1:0] DBW_READY = 2'd3;

	localparam logic [3:0] MS_ACTIVE    = 4'd1;
	localparam logic [3:0] MS_SUCCEEDED = 4'd3;
	localparam logic [3:0] MS_ABORTED   = 4'd4;

	localparam logic CFG_TIMEOUT = 1'b0;
	localparam logic CFG_HOLD    = 1'b1;

	typedef struct packed {
		logic [2:0]  op;
		logic [1:0]  dbw_code;
		logic [15:0] speed_in;
		logic [15:0] yaw_rate_in;
		logic        stop_request;
		logic        status_present;
		logic [3:0]  mission_code;
	} req_t;
endpackage

// File: hw/rtl/ahs_queue.sv
// short request queue between front and back
`timescale 1ns / 1ps
module ahs_queue import ahs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_req,
	output logic out_valid,
	input  logic out_ready,
	output req_t out_req
);
	req_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_req   = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// File: hw/rtl/ahs_divider.sv
// iterative signed q8.8 curvature divider, one quotient bit per cycle
`timescale 1ns / 1ps
module ahs_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] yaw,
	input  logic [15:0] speed,
	output logic        busy,
	output logic        done,
	output logic [15:0] quot
);
	logic [23:0] num_q;
	logic [23:0] rem_q;
	logic [15:0] den_q;
	logic        neg_q;
	logic [4:0]  cnt_q;
	logic        busy_q, done_q;
	logic [24:0] trial;
	logic [24:0] shifted;

	assign busy = busy_q;
	assign done = done_q;
	assign shifted = {rem_q, num_q[23]};
	assign trial = shifted - {9'd0, den_q};

	always_comb begin
		// 24 bits of magnitude quotient; saturate to q8.8 range
		if (neg_q) begin
			if (num_q > 24'd32768) quot = 16'h8000;
			else quot = 16'(-$signed({1'b0, num_q[15:0]}));
		end else begin
			if (num_q > 24'd32767) quot = 16'h7fff;
			else quot = num_q[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd24;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {(yaw[15] ? 16'(-yaw) : yaw), 8'd0};
			den_q <= speed[15] ? 16'(-speed) : speed;
			neg_q <= yaw[15] ^ speed[15];
			rem_q <= 24'd0;
		end else if (busy_q) begin
			if (!trial[24]) begin
				rem_q <= trial[23:0];
				num_q <= {num_q[22:0], 1'b1};
			end else begin
				rem_q <= shifted[23:0];
				num_q <= {num_q[22:0], 1'b0};
			end
		end
	end
endmodule

// File: hw/rtl/ahs_back.sv
// supervisor state, timers and result register
`timescale 1ns / 1ps
module ahs_back import ahs_pkg::*; #(
	parameter int TIMER_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [15:0] cfg_data,
	input  logic        q_valid,
	output logic        q_ready,
	input  req_t        q_req,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [39:0] res_data
);
	localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

	logic [15:0] tmo_q, hold_q;
	logic [2:0]  mode_q;
	logic [1:0]  dbw_q;
	logic [3:0]  mis_q;
	logic        run_q, cmp_q, abt_q, fault_q, stop_q;
	logic [TIMER_BITS-1:0] wd_q, sc_q;
	logic        wd_arm_q, sc_arm_q;
	logic [15:0] spd_q, curv_q;
	logic        div_wait_q;
	logic        div_start, div_busy, div_done;
	logic [15:0] div_quot;
	logic [TIMER_BITS-1:0] wd_lim, sc_lim, wd_nx, sc_nx;

	ahs_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.yaw(q_req.yaw_rate_in), .speed(q_req.speed_in),
		.busy(div_busy), .done(div_done), .quot(div_quot)
	);

	// limit clipped to timer range, zero acts as one
	function automatic logic [TIMER_BITS-1:0] clip(input logic [15:0] v);
		logic [TIMER_BITS-1:0] r;
		if (TIMER_BITS < 16 && (v >> TIMER_BITS) != 16'd0) r = TMAX;
		else r = TIMER_BITS'(v);
		if (r == '0) r = TIMER_BITS'(1);
		return r;
	endfunction

	assign wd_lim = clip(tmo_q);
	assign sc_lim = clip(hold_q);
	assign wd_nx = (wd_q == TMAX) ? wd_q : wd_q + TIMER_BITS'(1);
	assign sc_nx = (sc_q == TMAX) ? sc_q : sc_q + TIMER_BITS'(1);

	logic free;
	assign free = !res_valid || res_ready;
	assign q_ready = free && !div_wait_q && !div_busy && !div_done;
	logic take;
	assign take = q_valid && q_ready;
	assign div_start = take && q_req.op == OP_VEL && mode_q == MODE_RUN &&
		q_req.speed_in != 16'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tmo_q <= 16'd500;
			hold_q <= 16'd1000;
		end else if (cfg_we) begin
			if (cfg_idx == CFG_TIMEOUT) tmo_q <= cfg_data;
			else hold_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		logic [2:0] m;
		logic r, c, a;
		if (!arst_n) begin
			mode_q <= MODE_NOHB; dbw_q <= DBW_OFF; mis_q <= 4'd0;
			run_q <= 1'b0; cmp_q <= 1'b0; abt_q <= 1'b0;
			fault_q <= 1'b1; stop_q <= 1'b0;
			wd_q <= '0; sc_q <= '0; wd_arm_q <= 1'b0; sc_arm_q <= 1'b0;
			spd_q <= 16'd0; curv_q <= 16'd0;
			div_wait_q <= 1'b0; res_valid <= 1'b0;
		end else begin
			if (div_done) res_valid <= 1'b1;
			else if (take) res_valid <= !div_start;
			else if (res_ready) res_valid <= 1'b0;
			if (div_done) begin
				curv_q <= div_quot;
				div_wait_q <= 1'b0;
			end
			if (take) begin
				m = mode_q; r = run_q; c = cmp_q; a = abt_q;
				case (q_req.op)
					OP_TICK: begin
						if (wd_arm_q) begin
							wd_q <= wd_nx;
							if (wd_nx >= wd_lim) begin
								wd_arm_q <= 1'b0; fault_q <= 1'b1;
							end
						end
						if (sc_arm_q) begin
							sc_q <= sc_nx;
							if (sc_nx >= sc_lim) begin
								sc_arm_q <= 1'b0; stop_q <= 1'b0;
							end
						end
					end
					OP_VEL: begin
						wd_q <= '0; wd_arm_q <= 1'b1; fault_q <= 1'b0;
						if (mode_q == MODE_RUN) spd_q <= q_req.speed_in;
						else spd_q <= 16'd0;
						if (!(mode_q == MODE_RUN && q_req.speed_in != 16'd0))
							curv_q <= 16'd0;
					end
					OP_STOP: begin
						stop_q <= q_req.stop_request;
						if (q_req.stop_request && !sc_arm_q) begin
							sc_q <= '0; sc_arm_q <= 1'b1;
						end
					end
					OP_MISS: begin
						r = 1'b0; c = 1'b0; a = 1'b0;
						if (q_req.status_present) begin
							mis_q <= q_req.mission_code;
							if (mode_q == MODE_READY || mode_q == MODE_RUN) begin
								c = q_req.mission_code == MS_SUCCEEDED;
								r = q_req.mission_code == MS_ACTIVE && !stop_q;
								a = (q_req.mission_code == MS_ACTIVE && stop_q) ||
									q_req.mission_code == MS_ABORTED;
							end
						end
					end
					OP_MEAS, OP_UPD: begin
						logic [1:0] d;
						d = (q_req.op == OP_MEAS) ? q_req.dbw_code : dbw_q;
						dbw_q <= d;
						case (mode_q)
							MODE_NOHB: m = MODE_WAITHB;
							MODE_WAITHB: if (d != DBW_OFF) m = MODE_HAND;
							MODE_HAND: begin
								if (d == DBW_OFF) m = MODE_WAITHB;
								else if (d == DBW_READY) begin
									c = mis_q == MS_SUCCEEDED;
									r = mis_q == MS_ACTIVE && !stop_q;
									a = (mis_q == MS_ACTIVE && stop_q) ||
										mis_q == MS_ABORTED;
									m = (r || fault_q) ? MODE_HAND : MODE_READY;
								end
							end
							MODE_READY: begin
								if (d == DBW_OFF) m = MODE_WAITHB;
								else if (run_q) m = MODE_RUN;
								else if (fault_q || d != DBW_READY) m = MODE_HAND;
							end
							MODE_RUN: begin
								if (d == DBW_OFF) m = MODE_WAITHB;
								else if (cmp_q || abt_q || fault_q || d != DBW_READY)
									m = MODE_HAND;
							end
							default: m = MODE_NOHB;
						endcase
					end
					default: ;
				endcase
				mode_q <= m; run_q <= r; cmp_q <= c; abt_q <= a;
				if (div_start) div_wait_q <= 1'b1;
			end
		end
	end

	logic go;
	assign go = mode_q == MODE_RUN;
	assign res_data = {abt_q, cmp_q, run_q, stop_q, fault_q,
		go ? curv_q : 16'd0, go ? spd_q : 16'd0, mode_q};
endmodule

// File: hw/rtl/autonomy_handoff_supervisor.sv
// top level of the autonomy handoff supervisor
//  channel | direction | handshake         | payload
//  s_axis  | in        | tvalid / tready   | tdata 48 bits: op,dbw_code,speed_in,yaw_rate_in,
//          |           |                   |   stop_request,status_present,mission_code
//  m_axis  | out       | tvalid / tready   | tdata 40 bits: au_mode,speed_out,curvature_out,flags
//  cfg     | in        | cfg_we            | cfg_idx, cfg_data 16 bits
// one result per request; a velocity command in mission mode with nonzero speed
// waits for the 24 step divider, and no new request is taken until it finishes
// arst_n clears the control state; limits return to 500 and 1000 ticks
// the queue lets the input side fill while a result waits for m_axis_tready
`timescale 1ns / 1ps
module autonomy_handoff_supervisor import ahs_pkg::*; #(
	parameter int TIMER_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// op[2:0] dbw_code[4:3] speed_in[20:5] yaw_rate_in[36:21] stop_request[37]
	// status_present[38] mission_code[42:39] zero[47:43]
	input  logic [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// au_mode[2:0] speed_out[18:3] curvature_out[34:19] fault_flag[35]
	// stop_active[36] running_flag[37] complete_flag[38] aborted_flag[39]
	output logic [39:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [15:0] cfg_data
);
	req_t in_req, q_req;
	logic q_valid, q_ready;

	// front: unpack the request fields
	assign in_req.op = s_axis_tdata[2:0];
	assign in_req.dbw_code = s_axis_tdata[4:3];
	assign in_req.speed_in = s_axis_tdata[20:5];
	assign in_req.yaw_rate_in = s_axis_tdata[36:21];
	assign in_req.stop_request = s_axis_tdata[37];
	assign in_req.status_present = s_axis_tdata[38];
	assign in_req.mission_code = s_axis_tdata[42:39];

	ahs_queue u_q (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req(in_req),
		.out_valid(q_valid), .out_ready(q_ready), .out_req(q_req)
	);

	ahs_back #(.TIMER_BITS(TIMER_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_data(m_axis_tdata)
	);

	// speed and curvature are zero outside mission mode
	a_gate: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2:0] != MODE_RUN |-> m_axis_tdata[34:3] == 32'd0)
		else $error("speed or curvature leaked outside mission mode");
	// a held result stays stable
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");
	// mode never exceeds mission
	a_mode: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[2:0] <= MODE_RUN)
		else $error("bad mode reported");
endmodule

// File: test/autonomy_handoff_supervisor_test.sv
// testbench for the autonomy handoff supervisor: directed and random requests checked against a predictor
`timescale 1ns / 1ps
module autonomy_handoff_supervisor_test;
	import ahs_pkg::*;

	// one predicted result of the supervisor
	typedef struct {
		logic [2:0]  au_mode;
		logic [15:0] speed_out;
		logic [15:0] curvature_out;
		logic        fault_flag;
		logic        stop_active;
		logic        running_flag;
		logic        complete_flag;
		logic        aborted_flag;
	} status_t;

	// supervisor predictor and the queue of status reports still owed by the block
	class handoff_scoreboard;
		logic [15:0] timeout_lim, hold_lim;
		logic [2:0]  mode;
		logic [1:0]  dbw;
		logic [3:0]  mission;
		logic        running, complete, aborted, fault, stop;
		logic [16:0] wd_count, stop_count;
		logic        wd_armed, stop_armed;
		logic [15:0] speed_hold, curv_hold;
		status_t     owed[$];
		int          mismatches;

		function void clear_state();
			timeout_lim = 16'd500;
			hold_lim = 16'd1000;
			mode = MODE_NOHB;
			dbw = DBW_OFF;
			mission = 4'd0;
			running = 0;
			complete = 0;
			aborted = 0;
			fault = 1;
			wd_count = 0;
			stop_count = 0;
			wd_armed = 0;
			stop_armed = 0;
			stop = 0;
			speed_hold = 0;
			curv_hold = 0;
			mismatches = 0;
		endfunction

		function void write_reg(logic idx, logic [15:0] val);
			if (idx == CFG_TIMEOUT) timeout_lim = val;
			else hold_lim = val;
		endfunction

		// saturating count; true once the limit is reached (zero limit acts as one)
		function automatic logic bump(ref logic [16:0] cnt, input logic [15:0] lim);
			if (cnt < 17'h0ffff) cnt = cnt + 1;
			return cnt >= {1'b0, lim};
		endfunction

		function void score_flags(logic [2:0] m);
			running = 0;
			complete = 0;
			aborted = 0;
			if (m != MODE_READY && m != MODE_RUN) return;
			case (mission)
				MS_SUCCEEDED: complete = 1;
				MS_ACTIVE: begin
					running = !stop;
					aborted = stop;
				end
				MS_ABORTED: aborted = 1;
				default: ;
			endcase
		endfunction

		function void step_mode();
			case (mode)
				MODE_NOHB: mode = MODE_WAITHB;
				MODE_WAITHB: if (dbw != DBW_OFF) mode = MODE_HAND;
				MODE_HAND: begin
					if (dbw == DBW_OFF) mode = MODE_WAITHB;
					else if (dbw == DBW_READY) begin
						score_flags(MODE_READY);
						mode = (running || fault) ? MODE_HAND : MODE_READY;
					end
				end
				MODE_READY: begin
					if (dbw == DBW_OFF) mode = MODE_WAITHB;
					else if (running) mode = MODE_RUN;
					else if (fault || dbw != DBW_READY) mode = MODE_HAND;
				end
				MODE_RUN: begin
					if (dbw == DBW_OFF) mode = MODE_WAITHB;
					else if (complete || aborted || fault || dbw != DBW_READY)
						mode = MODE_HAND;
				end
				default: mode = MODE_NOHB;
			endcase
		endfunction

		function automatic logic [15:0] curvature(logic signed [15:0] sp,
				logic signed [15:0] yw);
			longint q;
			if (sp == 0) return 16'd0;
			q = (longint'(yw) * 256) / longint'(sp);
			if (q > 32767) q = 32767;
			if (q < -32768) q = -32768;
			return q[15:0];
		endfunction

		// note an accepted request and queue the status it should produce
		function void note_request(req_t r);
			status_t s;
			logic go;
			go = (mode == MODE_RUN);
			case (r.op)
				OP_TICK: begin
					if (wd_armed && bump(wd_count, timeout_lim)) begin
						wd_armed = 0;
						fault = 1;
					end
					if (stop_armed && bump(stop_count, hold_lim)) begin
						stop_armed = 0;
						stop = 0;
					end
				end
				OP_MEAS: begin
					dbw = r.dbw_code;
					step_mode();
				end
				OP_VEL: begin
					wd_count = 0;
					wd_armed = 1;
					fault = 0;
					speed_hold = go ? r.speed_in : 16'd0;
					curv_hold = go ? curvature(r.speed_in, r.yaw_rate_in) : 16'd0;
				end
				OP_STOP: begin
					stop = r.stop_request;
					if (stop && !stop_armed) begin
						stop_count = 0;
						stop_armed = 1;
					end
				end
				OP_MISS: begin
					if (r.status_present) begin
						mission = r.mission_code;
						score_flags(mode);
					end else begin
						running = 0;
						complete = 0;
						aborted = 0;
					end
				end
				OP_UPD: step_mode();
				default: ;
			endcase
			go = (mode == MODE_RUN);
			s.au_mode = mode;
			s.speed_out = go ? speed_hold : 16'd0;
			s.curvature_out = go ? curv_hold : 16'd0;
			s.fault_flag = fault;
			s.stop_active = stop;
			s.running_flag = running;
			s.complete_flag = complete;
			s.aborted_flag = aborted;
			owed.push_back(s);
		endfunction

		// compare one status report with the oldest one owed
		function void check_status(logic [39:0] d);
			status_t e;
			logic ok;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected status report %h", d);
				return;
			end
			e = owed.pop_front();
			ok = d[2:0] == e.au_mode && d[18:3] == e.speed_out
				&& d[34:19] == e.curvature_out && d[35] == e.fault_flag
				&& d[36] == e.stop_active && d[37] == e.running_flag
				&& d[38] == e.complete_flag && d[39] == e.aborted_flag;
			if (!ok) begin
				mismatches++;
				if (mismatches <= 10)
					$display("status mismatch: mode %0d/%0d speed %h/%h curv %h/%h flags %b/%b",
						e.au_mode, d[2:0], e.speed_out, d[18:3], e.curvature_out, d[34:19],
						{e.aborted_flag, e.complete_flag, e.running_flag, e.stop_active,
						e.fault_flag}, d[39:35]);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	// op[2:0] dbw_code[4:3] speed_in[20:5] yaw_rate_in[36:21] stop_request[37]
	// status_present[38] mission_code[42:39] zero[47:43]
	logic [47:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// au_mode[2:0] speed_out[18:3] curvature_out[34:19] fault_flag[35]
	// stop_active[36] running_flag[37] complete_flag[38] aborted_flag[39]
	logic [39:0] m_axis_tdata;
	logic        cfg_we;
	logic        cfg_idx;
	logic [15:0] cfg_data;

	handoff_scoreboard sb;
	int unsigned cycles;
	bit          sink_busy;   // lets the sink run without stalls for a while

	localparam int unsigned CYCLE_LIMIT = 2000000;

	autonomy_handoff_supervisor u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// cycle counter and timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		if ($urandom_range(0, 2) == 0) return 0;
		return $urandom_range(0, 3);
	endfunction

	// sink: check at the rising edge, change ready at the falling edge
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) sb.check_status(m_axis_tdata);
	end

	initial begin
		int g;
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (sink_busy) begin
				m_axis_tready = 1;
			end else begin
				g = gap_len();
				if (g > 0) begin
					m_axis_tready = 0;
					repeat (g) @(negedge clk);
				end
				m_axis_tready = 1;
				@(negedge clk);
				m_axis_tready = $urandom_range(0, 3) != 0;
			end
		end
	end

	// send one request; returns at the falling edge after the handshake
	task automatic send_request(req_t r);
		int g;
		g = gap_len();
		repeat (g) @(negedge clk);
		s_axis_tvalid = 1;
		s_axis_tdata = {5'd0, r.mission_code, r.status_present, r.stop_request,
			r.yaw_rate_in, r.speed_in, r.dbw_code, r.op};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(r);
		@(negedge clk);
		s_axis_tvalid = 0;
	endtask

	task automatic send_op(logic [2:0] op, logic [1:0] dbw, logic [15:0] sp,
			logic [15:0] yw, logic stp, logic pres, logic [3:0] mc);
		req_t r;
		r.op = op;
		r.dbw_code = dbw;
		r.speed_in = sp;
		r.yaw_rate_in = yw;
		r.stop_request = stp;
		r.status_present = pres;
		r.mission_code = mc;
		send_request(r);
	endtask

	// fully random request, every field bit free
	function automatic req_t noise_request();
		req_t r;
		r = req_t'(43'({$urandom, $urandom}));
		return r;
	endfunction

	// wait until every owed report has come, then let the divider settle
	task automatic drain();
		while (sb.owed.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		cfg_we = 1;
		cfg_idx = idx;
		cfg_data = val;
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_we = 0;
	endtask

	// walk the mode machine toward mission in progress with an active mission and a random velocity
	task automatic reach_mission();
		send_op(OP_MEAS, DBW_READY, 0, 0, 0, 0, 0);
		send_op(OP_UPD, 0, 0, 0, 0, 0, 0);
		send_op(OP_VEL, 0, 16'($urandom), 16'($urandom), 0, 0, 0);
		send_op(OP_UPD, 0, 0, 0, 0, 0, 0);
		send_op(OP_MISS, 0, 0, 0, 0, 1, MS_ACTIVE);
		send_op(OP_UPD, 0, 0, 0, 0, 0, 0);
	endtask

	// one random request biased toward a working mission
	task automatic random_request();
		int k;
		logic [15:0] sp;
		k = $urandom_range(0, 99);
		sp = 16'($urandom);
		if ($urandom_range(0, 3) == 0) sp = 16'($urandom_range(0, 3) - 1);
		if (k < 30) send_op(OP_TICK, 0, 0, 0, 0, 0, 0);
		else if (k < 45) send_op(OP_VEL, 0, sp, 16'($urandom), 0, 0, 0);
		else if (k < 55) send_op(OP_MEAS,
			($urandom_range(0, 5) == 0) ? 2'($urandom) : DBW_READY, 0, 0, 0, 0, 0);
		else if (k < 70) send_op(OP_UPD, 0, 0, 0, 0, 0, 0);
		else if (k < 78) send_op(OP_STOP, 0, 0, 0, 1'($urandom), 0, 0);
		else if (k < 88) send_op(OP_MISS, 0, 0, 0, 0, $urandom_range(0, 5) != 0,
			($urandom_range(0, 1) != 0) ? MS_ACTIVE : 4'($urandom_range(0, 15)));
		else if (k < 92) reach_mission();
		else send_request(noise_request());
	endtask

	initial begin
		logic [15:0] lims[4];
		sb = new();
		sb.clear_state();
		cycles = 0;
		sink_busy = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		cfg_we = 0;
		cfg_idx = CFG_TIMEOUT;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: modes, extremes of speed and yaw, stop held, flags
		send_op(OP_UPD, 0, 0, 0, 0, 0, 0);
		send_op(OP_MEAS, 2'd1, 0, 0, 0, 0, 0);
		send_op(OP_MEAS, DBW_READY, 0, 0, 0, 0, 0);
		send_op(OP_VEL, 0, 16'h0100, 16'h0100, 0, 0, 0);
		send_op(OP_MISS, 0, 0, 0, 0, 1, MS_ACTIVE);
		send_op(OP_UPD, 0, 0, 0, 0, 0, 0);
		send_op(OP_MISS, 0, 0, 0, 0, 1, MS_ACTIVE);
		send_op(OP_UPD, 0, 0, 0, 0, 0, 0);
		send_op(OP_VEL, 0, 16'h0001, 16'h7fff, 0, 0, 0);
		send_op(OP_VEL, 0, 16'h8000, 16'h8000, 0, 0, 0);
		send_op(OP_VEL, 0, 16'hffff, 16'h8000, 0, 0, 0);
		send_op(OP_VEL, 0, 16'h0000, 16'h1234, 0, 0, 0);
		send_op(OP_VEL, 0, 16'h7fff, 16'hffff, 0, 0, 0);
		send_op(OP_STOP, 0, 0, 0, 1, 0, 0);
		send_op(OP_STOP, 0, 0, 0, 1, 0, 0);
		send_op(OP_MISS, 0, 0, 0, 0, 1, MS_ACTIVE);
		send_op(OP_STOP, 0, 0, 0, 0, 0, 0);
		send_op(OP_MISS, 0, 0, 0, 0, 1, MS_SUCCEEDED);
		send_op(OP_MISS, 0, 0, 0, 0, 1, MS_ABORTED);
		send_op(OP_MISS, 0, 0, 0, 0, 1, 4'd15);
		send_op(OP_MISS, 0, 0, 0, 0, 0, MS_ACTIVE);
		send_op(3'd6, 2'd3, 16'hffff, 16'hffff, 1, 1, 4'hf);
		send_op(3'd7, 0, 0, 0, 0, 0, 0);
		send_op(OP_MEAS, DBW_OFF, 0, 0, 0, 0, 0);
		send_op(OP_TICK, 0, 0, 0, 0, 0, 0);
		drain();

		// random phases through several timer settings, extremes among them
		lims[0] = 16'd1;
		lims[1] = 16'd0;
		lims[2] = 16'hffff;
		lims[3] = 16'd3;
		for (int ph = 0; ph < 8; ph++) begin
			if (ph < 4) begin
				write_reg(CFG_TIMEOUT, lims[ph]);
				write_reg(CFG_HOLD, lims[3 - ph]);
			end else begin
				write_reg(CFG_TIMEOUT, 16'($urandom_range(1, 12)));
				write_reg(CFG_HOLD, 16'($urandom_range(1, 20)));
			end
			sink_busy = (ph == 5);
			for (int i = 0; i < 140; i++) random_request();
			drain();
		end

		if (sb.mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

// File: autonomy_handoff_supervisor.f
hw/rtl/ahs_pkg.sv
hw/rtl/ahs_queue.sv
hw/rtl/ahs_divider.sv
hw/rtl/ahs_back.sv
hw/rtl/autonomy_handoff_supervisor.sv
test/autonomy_handoff_supervisor_test.sv
